// ----- hw/rtl/ctcgd_pkg.sv -----
package ctcgd_pkg;

  localparam int unsigned MaxVocab   = 4096;
  localparam int unsigned IndexW     = 12;
  localparam int unsigned VocabW     = 13;
  localparam int unsigned ScoreW     = 32;
  localparam int unsigned StampW     = 32;
  localparam int unsigned RunW       = 16;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned OutDataW   = 64;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam logic [VocabW-1:0] VocabMax   = VocabW'(MaxVocab);
  localparam logic [VocabW-1:0] VocabReset = VocabW'(MaxVocab);
  localparam logic [RunW-1:0]   RunMax     = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLANK_TOKEN = 8'd0,
    CFG_FRAME_SIZE  = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [IndexW-1:0] blank_token;
    logic [VocabW-1:0] frame_size;
  } cfg_t;

  typedef struct packed {
    logic              chunk_end;
    logic [IndexW-1:0] index;
  } frame_t;

endpackage

// ----- hw/rtl/ctcgd_front.sv -----
module ctcgd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctcgd_pkg::cfg_t            cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ctcgd_pkg::ScoreW-1:0] score_i,
  input  logic                       chunk_end_i,
  output logic                       push_o,
  output ctcgd_pkg::frame_t          frame_o,
  input  logic                       full_i
);
  import ctcgd_pkg::*;

  logic [IndexW-1:0] score_index_q, score_index_d;
  logic [IndexW-1:0] best_index_q, best_index_d;
  logic signed [ScoreW-1:0] best_score_q, best_score_d;
  logic [VocabW-1:0] frame_len;
  logic              last;
  logic              take;
  logic              accept;
  logic [IndexW-1:0] win_index;

  always_comb begin
    if (cfg_i.frame_size == '0) begin
      frame_len = VocabW'(1);
    end else if (cfg_i.frame_size > VocabMax) begin
      frame_len = VocabMax;
    end else begin
      frame_len = cfg_i.frame_size;
    end
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = ({1'b0, score_index_q} + VocabW'(1)) >= frame_len;
  assign take       = (score_index_q == '0) || ($signed(score_i) > best_score_q);
  assign win_index  = take ? score_index_q : best_index_q;

  always_comb begin
    score_index_d = score_index_q;
    best_index_d  = best_index_q;
    best_score_d  = best_score_q;
    if (accept) begin
      if (take) begin
        best_index_d = score_index_q;
        best_score_d = $signed(score_i);
      end
      score_index_d = last ? '0 : score_index_q + IndexW'(1);
    end
  end

  assign push_o          = accept && last;
  assign frame_o.index     = win_index;
  assign frame_o.chunk_end = chunk_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_index_q <= '0;
      best_index_q  <= '0;
      best_score_q  <= '0;
    end else begin
      score_index_q <= score_index_d;
      best_index_q  <= best_index_d;
      best_score_q  <= best_score_d;
    end
  end

endmodule

// ----- hw/rtl/ctcgd_queue.sv -----
module ctcgd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ctcgd_pkg::frame_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ctcgd_pkg::frame_t pop_data_o
);
  import ctcgd_pkg::*;

  frame_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o     = count_q == QCntW'(QDepth);
  assign valid_o    = count_q != '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/ctcgd_back.sv -----
module ctcgd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctcgd_pkg::cfg_t               cfg_i,
  input  logic                          q_valid_i,
  input  ctcgd_pkg::frame_t             q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          emit_o,
  output logic [ctcgd_pkg::IndexW-1:0]  token_o,
  output logic [ctcgd_pkg::StampW-1:0]  timestamp_o,
  output logic [ctcgd_pkg::RunW-1:0]    trailing_blanks_o
);
  import ctcgd_pkg::*;

  logic              out_valid_q, out_valid_d;
  logic              emit_q, emit_d;
  logic [IndexW-1:0] token_q;
  logic [StampW-1:0] stamp_q;
  logic [RunW-1:0]   run_out_q;
  logic [IndexW-1:0] prev_token_q;
  logic              prev_valid_q;
  logic [StampW-1:0] frame_count_q;
  logic [RunW-1:0]   blank_run_q, blank_run_d;
  logic              is_blank;

  assign pop_o    = q_valid_i && (!out_valid_q || out_ready_i);
  assign is_blank = q_data_i.index == cfg_i.blank_token;

  always_comb begin
    if (!is_blank) begin
      blank_run_d = '0;
    end else if (blank_run_q == RunMax) begin
      blank_run_d = blank_run_q;
    end else begin
      blank_run_d = blank_run_q + RunW'(1);
    end
    emit_d = !is_blank && !(prev_valid_q && (q_data_i.index == prev_token_q));
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      emit_q    <= emit_d;
      token_q   <= q_data_i.index;
      stamp_q   <= frame_count_q;
      run_out_q <= blank_run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      prev_token_q  <= '0;
      prev_valid_q  <= 1'b0;
      frame_count_q <= '0;
      blank_run_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        prev_token_q  <= q_data_i.index;
        prev_valid_q  <= !q_data_i.chunk_end;
        frame_count_q <= frame_count_q + StampW'(1);
        blank_run_q   <= blank_run_d;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign emit_o            = emit_q;
  assign token_o           = token_q;
  assign timestamp_o       = stamp_q;
  assign trailing_blanks_o = run_out_q;

endmodule

// ----- hw/rtl/ctc_greedy_decoder_core.sv -----
// Result path: a frame's winner enters the queue at the edge that takes its last score,
//   then the output register once the queue ahead of it is empty and the output is free.
// Throughput: one score per cycle while the queue has room, set by the running-max
//   compare in the front; one result per frame, one per cycle for one-score frames.
// Reset: async active low; blank_token 0, frame size 4096, frame position, previous
//   winner, frame counter and blank run cleared, queue and output register empty.
module ctc_greedy_decoder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ctcgd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ctcgd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ctcgd_pkg::InDataW-1:0]   s_axis_tdata,  // score[31:0]
  input  logic                            s_axis_tlast,  // chunk_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // token[11:0], timestamp[43:12], trailing_blanks[59:44], zero[63:60]
  output logic [ctcgd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                            m_axis_tuser   // emit
);
  import ctcgd_pkg::*;

  cfg_t              cfg_q;
  frame_t            push_data, pop_data;
  logic              push, pop, q_full, q_valid;
  logic              emit;
  logic [IndexW-1:0] token;
  logic [StampW-1:0] stamp;
  logic [RunW-1:0]   run;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blank_token <= '0;
      cfg_q.frame_size  <= VocabReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BLANK_TOKEN: cfg_q.blank_token <= cfg_data_i[IndexW-1:0];
        CFG_FRAME_SIZE:  cfg_q.frame_size  <= cfg_data_i[VocabW-1:0];
        default: ;
      endcase
    end
  end

  ctcgd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .score_i     (s_axis_tdata[ScoreW-1:0]),
    .chunk_end_i (s_axis_tlast),
    .push_o      (push),
    .frame_o     (push_data),
    .full_i      (q_full)
  );

  ctcgd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  ctcgd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_valid_i         (q_valid),
    .q_data_i          (pop_data),
    .pop_o             (pop),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .emit_o            (emit),
    .token_o           (token),
    .timestamp_o       (stamp),
    .trailing_blanks_o (run)
  );

  assign m_axis_tuser = emit;
  assign m_axis_tdata = {(OutDataW - IndexW - StampW - RunW)'(0), run, stamp, token};

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("frame queue overflow");

  a_emit_not_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (token != cfg_q.blank_token))
    else $error("blank token emitted");

  a_run_matches_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((token == cfg_q.blank_token) == (run != '0)))
    else $error("trailing blank count disagrees with winner");

  a_stamp_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && $past(pop) && rst_ni && $past(rst_ni)) |=> (stamp == $past(stamp) + StampW'(1)))
    else $error("timestamp did not advance by one");

endmodule

// ----- test/ctc_greedy_decoder_core_tb.sv -----
`timescale 1ns / 1ps

module ctc_greedy_decoder_core_tb;
  import ctcgd_pkg::*;

  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 4;
  localparam logic [CfgIdxW-1:0] CfgIdxNone = 8'hFF;
  localparam logic [ScoreW-1:0] ScoreMax = 32'h7FFF_FFFF;
  localparam logic [ScoreW-1:0] ScoreMin = 32'h8000_0000;

  typedef struct packed {
    logic              emit;
    logic [IndexW-1:0] token;
    logic [StampW-1:0] stamp;
    logic [RunW-1:0]   run;
  } frame_result_t;

  typedef enum logic {ROW_SCORE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] data;
    logic [ScoreW-1:0]  score;
    logic               chunk;
    logic               typed;
    frame_result_t      want;
  } row_t;

  localparam frame_result_t NoFrame = '0;

  localparam row_t DirectedRows [25] = '{
    '{ROW_CFG,   CFG_FRAME_SIZE,  16'd2,      32'd0,        1'b0, 1'b0, NoFrame},
    '{ROW_CFG,   CFG_BLANK_TOKEN, 16'd0,      32'd0,        1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      ScoreMin,     1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      ScoreMin,     1'b0, 1'b1,
      '{1'b0, 12'd0, 32'd0, 16'd1}},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'd5,        1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      ScoreMax,     1'b0, 1'b1,
      '{1'b1, 12'd1, 32'd1, 16'd0}},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'hFFFF_FFFF, 1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'd3,        1'b1, 1'b1,
      '{1'b0, 12'd1, 32'd2, 16'd0}},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'd0,        1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'd9,        1'b0, 1'b1,
      '{1'b1, 12'd1, 32'd3, 16'd0}},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      ScoreMax,     1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      ScoreMax,     1'b0, 1'b1,
      '{1'b0, 12'd0, 32'd4, 16'd1}},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'd1,        1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'd0,        1'b0, 1'b1,
      '{1'b0, 12'd0, 32'd5, 16'd2}},
    '{ROW_CFG,   CFG_BLANK_TOKEN, 16'hFFFF,   32'd0,        1'b0, 1'b0, NoFrame},
    '{ROW_CFG,   CfgIdxNone,      16'hFFFF,   32'd0,        1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'd2,        1'b1, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'd1,        1'b0, 1'b1,
      '{1'b0, 12'd0, 32'd6, 16'd0}},
    '{ROW_CFG,   CFG_FRAME_SIZE,  16'd0,      32'd0,        1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'd7,        1'b0, 1'b1,
      '{1'b0, 12'd0, 32'd7, 16'd0}},
    '{ROW_CFG,   CFG_FRAME_SIZE,  16'd4,      32'd0,        1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'd1,        1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      ScoreMax,     1'b0, 1'b0, NoFrame},
    '{ROW_CFG,   CFG_FRAME_SIZE,  16'd2,      32'd0,        1'b0, 1'b0, NoFrame},
    '{ROW_SCORE, CfgIdxNone,      16'd0,      32'h7FFF_FFFE, 1'b0, 1'b1,
      '{1'b1, 12'd1, 32'd8, 16'd0}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  // expectation typed in by the directed table, travels with the word
  logic          typed_frame_valid = 1'b0;
  frame_result_t typed_frame = '0;

  logic hold_req = 1'b0;
  bit   hold_done;
  int   burst_left;
  int   fail_count;

  // decoder state mirror
  logic [IndexW-1:0]        blank_reg;
  logic [VocabW-1:0]        vocab_reg;
  logic signed [ScoreW-1:0] best_score;
  int unsigned              best_pos;
  int unsigned              frame_pos;
  logic [IndexW-1:0]        last_token;
  logic                     last_valid;
  logic [StampW-1:0]        frame_no;
  logic [RunW-1:0]          blank_streak;

  frame_result_t pending_frames[$];

  ctc_greedy_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic bit advance_decoder(input logic signed [ScoreW-1:0] s,
                                         input logic chunk,
                                         output frame_result_t r);
    int unsigned len;
    logic [IndexW-1:0] win;
    bit is_blank;
    len = (vocab_reg == 0) ? 1 : ((vocab_reg > MaxVocab) ? MaxVocab : vocab_reg);
    r = '0;
    if (frame_pos == 0 || s > best_score) begin
      best_score = s;
      best_pos = frame_pos;
    end
    if (frame_pos + 1 < len) begin
      frame_pos++;
      return 1'b0;
    end
    win = best_pos[IndexW-1:0];
    is_blank = (win == blank_reg);
    if (!is_blank) begin
      blank_streak = '0;
    end else if (blank_streak != RunMax) begin
      blank_streak++;
    end
    r.emit = !is_blank && !(last_valid && win == last_token);
    r.token = win;
    r.stamp = frame_no;
    r.run = blank_streak;
    last_token = win;
    last_valid = !chunk;
    frame_no++;
    frame_pos = 0;
    best_pos = 0;
    best_score = '0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    frame_result_t r;
    frame_result_t want;
    if (!rst_ni) begin
      blank_reg = '0;
      vocab_reg = VocabReset;
      best_score = '0;
      best_pos = 0;
      frame_pos = 0;
      last_token = '0;
      last_valid = 1'b0;
      frame_no = '0;
      blank_streak = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_BLANK_TOKEN) begin
          blank_reg = cfg_data_i[IndexW-1:0];
        end else if (cfg_index_i == CFG_FRAME_SIZE) begin
          vocab_reg = cfg_data_i[VocabW-1:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (advance_decoder(s_axis_tdata, s_axis_tlast, r) || typed_frame_valid)
          pending_frames.insert(pending_frames.size(), typed_frame_valid ? typed_frame : r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_frames.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none got tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = pending_frames.pop_front();
          check_field("emit", want.emit, m_axis_tuser);
          check_field("token", want.token, m_axis_tdata[11:0]);
          check_field("timestamp", want.stamp, m_axis_tdata[43:12]);
          check_field("trailing_blanks", want.run, m_axis_tdata[59:44]);
          check_field("pad", '0, m_axis_tdata[63:60]);
        end
      end
    end
  end

  // receiver: ready pattern in stretches, plus one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // called and returns at a falling edge
  task automatic offer_score(input logic [ScoreW-1:0] score, input logic chunk,
                             input logic typed, input frame_result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= score;
    s_axis_tlast <= chunk;
    typed_frame_valid <= typed;
    typed_frame <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // called and returns at a falling edge; drains the block first
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned vocab;
    int unsigned span;
    int unsigned pick;
    int unsigned style;
    int unsigned n;
    logic [IndexW-1:0] blank;
    logic [ScoreW-1:0] s;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].kind == ROW_CFG)
        write_reg(DirectedRows[i].idx, DirectedRows[i].data);
      else
        offer_score(DirectedRows[i].score, DirectedRows[i].chunk,
                    DirectedRows[i].typed, DirectedRows[i].want);
    end

    // one-score frames while the receiver holds off
    write_reg(CFG_FRAME_SIZE, 16'd1);
    hold_req <= 1'b1;
    repeat (80) offer_score(32'($urandom), 1'($urandom_range(0, 1)), 1'b0, NoFrame);

    for (int p = 0; p < 28; p++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) vocab = $urandom_range(0, 1);
      else if (pick == 19) vocab = $urandom_range(13, 300);
      else vocab = $urandom_range(2, 12);
      span = (vocab < 2) ? 2 : vocab;
      blank = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(0, span - 1));
      write_reg(CFG_FRAME_SIZE, {3'($urandom), 13'(vocab)});
      write_reg(CFG_BLANK_TOKEN, {4'($urandom), blank});
      style = $urandom_range(0, 3);
      n = $urandom_range(25, 55);
      repeat (n) begin
        case (style)
          0: s = 32'($urandom);
          1: s = 32'($urandom_range(0, 4)) - 32'd2;
          2: begin
            case ($urandom_range(0, 3))
              0: s = ScoreMin;
              1: s = ScoreMax;
              2: s = '0;
              default: s = '1;
            endcase
          end
          default: s = (frame_pos == blank) ? ScoreMax : 32'($urandom_range(0, 1000));
        endcase
        offer_score(s, $urandom_range(0, 4) == 0, 1'b0, NoFrame);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(64'd2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ctcgd_pkg.sv
hw/rtl/ctcgd_front.sv
hw/rtl/ctcgd_queue.sv
hw/rtl/ctcgd_back.sv
hw/rtl/ctc_greedy_decoder_core.sv
test/ctc_greedy_decoder_core_tb.sv
